>>> hdl/image_gradient_central_difference_unit_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef IMAGE_GRADIENT_CENTRAL_DIFFERENCE_UNIT_MACROS_SVH
`define IMAGE_GRADIENT_CENTRAL_DIFFERENCE_UNIT_MACROS_SVH

// same-cycle implication
`define IGCD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IGCD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/igcd_pkg.sv
package igcd_pkg;

  localparam int CFG_DATA_BITS   = 13;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int ROW_BITS        = 12;
  localparam int MIN_SIZE        = 2;
  localparam int MAX_HEIGHT      = 4096;
  localparam int SIZE_RESET      = 1024;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = 2;
  localparam int QUEUE_CNT_BITS  = 3;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    HM_FORWARD,
    HM_BACKWARD,
    HM_CENTRAL
  } hmode_t;

  typedef enum logic [1:0] {
    VM_FORWARD,
    VM_BACKWARD,
    VM_CENTRAL
  } vmode_t;

  typedef struct packed {
    logic   emit;
    logic   last;
    logic   right_ok;
    logic   fwd;
    hmode_t hmode;
    vmode_t vmode;
  } s1_ctrl_t;

endpackage

>>> hdl/igcd_in_if.sv
interface igcd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_of_frame;

  modport source(output valid, output sample, output start_of_frame, input ready);
  modport sink(input valid, input sample, input start_of_frame, output ready);
endinterface

>>> hdl/igcd_out_if.sv
interface igcd_out_if #(
  parameter int SAMPLE_BITS = 16
);
  localparam int OUT_BITS = SAMPLE_BITS + 2;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] horiz_derivative;
  logic signed [OUT_BITS-1:0] vert_derivative;
  logic                       last_of_frame;

  modport source(output valid, output horiz_derivative, output vert_derivative,
                 output last_of_frame, input ready);
  modport sink(input valid, input horiz_derivative, input vert_derivative,
               input last_of_frame, output ready);
endinterface

>>> hdl/image_gradient_central_difference_unit.sv
// Streaming central-difference gradient. Samples enter in raster order at one item per clock;
// the only stall comes from the output side, when the four-entry result queue together with
// the item in the compute stage is full. Each result carries d/dx and d/dy in half units and
// leaves one row after its pixel (the bottom row of a frame drains while the first row of the
// next frame arrives), after the compute stage and the result queue. Two line memories of
// MAX_WIDTH entries hold the two rows above; each item reads them on acceptance and the
// compute stage writes the row shift back in the next cycle, bypassed when two back-to-back
// items land on the same column. The line memories need no clearing pass after reset.
`include "image_gradient_central_difference_unit_macros.svh"

module image_gradient_central_difference_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  igcd_in_if.sink                            in_chan,
  igcd_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  igcd_pkg::cfg_idx_t                 cfg_idx,
  input  logic [igcd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import igcd_pkg::*;

  localparam int AW             = $clog2(MAX_WIDTH);
  localparam int WW             = $clog2(MAX_WIDTH + 1);
  localparam int OB             = SAMPLE_BITS + 2;
  localparam int RB             = 2 * OB + 1;
  localparam int WIDTH_AT_RESET = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [SAMPLE_BITS:0]   dif_t;

  // configuration
  logic [WIDTH_REG_BITS-1:0]  frame_width_r;
  logic [HEIGHT_REG_BITS-1:0] frame_height_r;
  logic [WW-1:0]              width_clamped;
  logic [HEIGHT_REG_BITS-1:0] height_clamped;

  // position state
  logic [ROW_BITS-1:0]        row_r;
  logic [AW-1:0]              col_r;
  logic [WW-1:0]              cur_width_r;
  logic [HEIGHT_REG_BITS-1:0] cur_height_r;
  logic                       flush_pend_r;
  logic [WW-1:0]              flush_width_r;

  // accept stage
  logic                       acc;
  logic                       sof;
  logic [ROW_BITS-1:0]        row0;
  logic [AW-1:0]              col0;
  logic                       fp0;
  logic                       at_origin;
  logic [WW-1:0]              cw;
  logic [HEIGHT_REG_BITS-1:0] ch;
  logic [WW-1:0]              c1;
  logic                       do_flush;
  logic [WW-1:0]              wlim;
  logic [AW-1:0]              right_addr;
  s1_ctrl_t                   ctrl0;
  logic [ROW_BITS-1:0]        row_nxt;
  logic [AW-1:0]              col_nxt;
  logic                       flush_pend_nxt;
  logic [WW-1:0]              flush_width_nxt;

  // line memories
  smp_t prev_mem  [MAX_WIDTH];
  smp_t older_mem [MAX_WIDTH];
  smp_t rd_mid_r;
  smp_t rd_right_r;
  smp_t rd_old_r;

  // compute stage
  logic            s1_valid_r;
  s1_ctrl_t        s1_ctrl_r;
  smp_t            s1_sample_r;
  logic [AW-1:0]   s1_col_r;
  smp_t            fwd_val_r;
  smp_t            left_r;
  smp_t            mid;
  smp_t            right;
  smp_t            above2;
  dif_t            d_rm;
  dif_t            d_ml;
  dif_t            d_rl;
  dif_t            d_ma;
  dif_t            d_sm;
  dif_t            d_sa;
  logic signed [OB-1:0] horiz;
  logic signed [OB-1:0] vert;

  // result queue
  logic                      q_push;
  logic                      q_pop;
  logic                      q_head_valid;
  logic [RB-1:0]             q_head;
  logic [QUEUE_CNT_BITS-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_REG_BITS'(SIZE_RESET);
      frame_height_r <= HEIGHT_REG_BITS'(SIZE_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[WIDTH_REG_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(frame_width_r) < 32'(MIN_SIZE)) begin
      width_clamped = WW'(MIN_SIZE);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = WW'(frame_width_r);
    end
    if (32'(frame_height_r) < 32'(MIN_SIZE)) begin
      height_clamped = HEIGHT_REG_BITS'(MIN_SIZE);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      height_clamped = HEIGHT_REG_BITS'(MAX_HEIGHT);
    end else begin
      height_clamped = frame_height_r;
    end
  end

  assign acc = in_chan.valid && in_chan.ready;
  assign sof = in_chan.start_of_frame;

  always_comb begin
    row0      = sof ? '0 : row_r;
    col0      = sof ? '0 : col_r;
    fp0       = flush_pend_r && !(sof && (row_r != '0 || col_r != '0));
    at_origin = (row0 == '0) && (col0 == '0);
    cw        = at_origin ? width_clamped : cur_width_r;
    ch        = at_origin ? height_clamped : cur_height_r;
    c1        = WW'(col0) + WW'(1);
    do_flush  = fp0 && (row0 == '0) && (WW'(col0) < flush_width_r);
    wlim      = do_flush ? flush_width_r : cw;

    ctrl0.emit     = do_flush || (row0 != '0);
    ctrl0.last     = do_flush && (c1 == flush_width_r);
    ctrl0.right_ok = (c1 < wlim);
    ctrl0.fwd      = s1_valid_r && (s1_col_r == col0);
    if (col0 == '0) begin
      ctrl0.hmode = HM_FORWARD;
    end else if (c1 >= wlim) begin
      ctrl0.hmode = HM_BACKWARD;
    end else begin
      ctrl0.hmode = HM_CENTRAL;
    end
    if (do_flush) begin
      ctrl0.vmode = VM_BACKWARD;
    end else if (row0 == ROW_BITS'(1)) begin
      ctrl0.vmode = VM_FORWARD;
    end else begin
      ctrl0.vmode = VM_CENTRAL;
    end
    right_addr = ctrl0.right_ok ? AW'(c1) : col0;

    row_nxt         = row0;
    col_nxt         = col0;
    flush_pend_nxt  = fp0;
    flush_width_nxt = flush_width_r;
    if (c1 < cw) begin
      col_nxt = AW'(c1);
    end else begin
      col_nxt = '0;
      if (row0 == '0) begin
        flush_pend_nxt = 1'b0;
      end
      if ({1'b0, row0} + HEIGHT_REG_BITS'(1) < ch) begin
        row_nxt = row0 + ROW_BITS'(1);
      end else begin
        row_nxt         = '0;
        flush_pend_nxt  = 1'b1;
        flush_width_nxt = cw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r         <= '0;
      col_r         <= '0;
      cur_width_r   <= WW'(WIDTH_AT_RESET);
      cur_height_r  <= HEIGHT_REG_BITS'(SIZE_RESET);
      flush_pend_r  <= 1'b0;
      flush_width_r <= '0;
      s1_valid_r    <= 1'b0;
      left_r        <= '0;
    end else begin
      s1_valid_r <= acc;
      if (acc) begin
        row_r         <= row_nxt;
        col_r         <= col_nxt;
        cur_width_r   <= cw;
        cur_height_r  <= ch;
        flush_pend_r  <= flush_pend_nxt;
        flush_width_r <= flush_width_nxt;
      end
      if (s1_valid_r) begin
        left_r <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctrl_r   <= ctrl0;
      s1_sample_r <= in_chan.sample;
      s1_col_r    <= col0;
      fwd_val_r   <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prev_mem[col0] <= in_chan.sample;
      rd_mid_r       <= prev_mem[col0];
      rd_right_r     <= prev_mem[right_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      older_mem[s1_col_r] <= mid;
    end
    if (acc) begin
      rd_old_r <= older_mem[col0];
    end
  end

  always_comb begin
    mid    = rd_mid_r;
    right  = s1_ctrl_r.right_ok ? rd_right_r : rd_mid_r;
    above2 = s1_ctrl_r.fwd ? fwd_val_r : rd_old_r;

    d_rm = {right[SAMPLE_BITS-1], right} - {mid[SAMPLE_BITS-1], mid};
    d_ml = {mid[SAMPLE_BITS-1], mid} - {left_r[SAMPLE_BITS-1], left_r};
    d_rl = {right[SAMPLE_BITS-1], right} - {left_r[SAMPLE_BITS-1], left_r};
    d_ma = {mid[SAMPLE_BITS-1], mid} - {above2[SAMPLE_BITS-1], above2};
    d_sm = {s1_sample_r[SAMPLE_BITS-1], s1_sample_r} - {mid[SAMPLE_BITS-1], mid};
    d_sa = {s1_sample_r[SAMPLE_BITS-1], s1_sample_r} - {above2[SAMPLE_BITS-1], above2};

    case (s1_ctrl_r.hmode)
      HM_FORWARD:  horiz = {d_rm, 1'b0};
      HM_BACKWARD: horiz = {d_ml, 1'b0};
      HM_CENTRAL:  horiz = {d_rl[SAMPLE_BITS], d_rl};
      default:     horiz = '0;
    endcase

    case (s1_ctrl_r.vmode)
      VM_FORWARD:  vert = {d_sm, 1'b0};
      VM_BACKWARD: vert = {d_ma, 1'b0};
      VM_CENTRAL:  vert = {d_sa[SAMPLE_BITS], d_sa};
      default:     vert = '0;
    endcase
  end

  assign q_push = s1_valid_r && s1_ctrl_r.emit;
  assign q_pop  = out_chan.valid && out_chan.ready;

  igcd_result_queue #(
    .DATA_BITS(RB)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({horiz, vert, s1_ctrl_r.last}),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_data (q_head),
    .count     (q_count)
  );

  assign in_chan.ready = (q_count + QUEUE_CNT_BITS'(s1_valid_r))
                         < QUEUE_CNT_BITS'(QUEUE_DEPTH);

  assign out_chan.valid            = q_head_valid;
  assign out_chan.horiz_derivative = q_head[RB-1 -: OB];
  assign out_chan.vert_derivative  = q_head[OB:1];
  assign out_chan.last_of_frame    = q_head[0];

  `IGCD_ASSERT_IMP(a_queue_room, s1_valid_r, q_count < QUEUE_CNT_BITS'(QUEUE_DEPTH), "result queue overrun")
  `IGCD_ASSERT_IMP(a_last_on_right_edge, s1_valid_r && s1_ctrl_r.last, s1_ctrl_r.emit && s1_ctrl_r.hmode == HM_BACKWARD, "last item not at right edge")
  `IGCD_ASSERT_IMP(a_col_in_frame, 1'b1, WW'(col_r) < cur_width_r, "column beyond frame width")
  `IGCD_ASSERT_NXT(a_push_shows, q_push, out_chan.valid, "pushed item not presented")

endmodule

>>> hdl/igcd_result_queue.sv
module igcd_result_queue #(
  parameter int DATA_BITS = 37
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [DATA_BITS-1:0]                push_data,
  input  logic                                pop,
  output logic                                head_valid,
  output logic [DATA_BITS-1:0]                head_data,
  output logic [igcd_pkg::QUEUE_CNT_BITS-1:0] count
);
  import igcd_pkg::*;

  logic [DATA_BITS-1:0]      slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r;
  logic [QUEUE_CNT_BITS-1:0] count_r;
  logic [QUEUE_CNT_BITS-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QUEUE_CNT_BITS'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - QUEUE_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_BITS'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign count      = count_r;

endmodule
